FILE: hw/rtl/cba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_SPACE   = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Request word
    typedef struct packed {
        logic        mode;
        logic [15:0] length;
        logic [15:0] block_base;
        logic [7:0]  owner_id;
    } cba_req_t;

    // Result word
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_base;
        logic [15:0] top;
    } cba_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/compacting_bump_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Compacting bump allocator. Blocks are handed out from a top pointer that
// starts at slot 1; a free removes the block matching base and owner and
// slides every block above it down, so the allocated space stays gap free.
// The block table (base, length, owner) sits in two one-port-read,
// one-port-write synchronous memories; valid bits and the top pointer are
// flip-flops. One request is processed at a time. An allocate scans the
// valid bits one entry a cycle for the lowest free entry; a zero length
// is answered without a scan. A free walks the table twice through the
// memory read port, once to find the match and once to rebase the blocks
// above it, and walks it only once when nothing matches. The result sits
// in an output register, so the next request is taken while it waits.
module compacting_bump_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int ADDR_BITS  = 16,
    parameter int OWNER_BITS = 8
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire cba_pkg::cba_req_t s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output cba_pkg::cba_rsp_t  m_data
);

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int INFO_W = 16 + OWNER_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);
    localparam logic [32:0] ADDR_LIMIT = 33'((64'd1 << ADDR_BITS) - 64'd1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEARCH,
        S_COMPACT,
        S_DELIVER
    } state_t;

    // Table memories
    logic [ADDR_BITS-1:0] base_mem [MAX_BLOCKS];
    logic [INFO_W-1:0]    info_mem [MAX_BLOCKS];

    state_t               state_reg, state_next;
    cba_pkg::cba_req_t    req_reg, req_next;
    logic [MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [ADDR_BITS-1:0] top_reg, top_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [15:0]          flen_reg, flen_next;
    logic [ADDR_BITS-1:0] fbase_reg, fbase_next;
    cba_pkg::cba_rsp_t    res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    cba_pkg::cba_rsp_t    m_data_reg, m_data_next;

    logic [ADDR_BITS-1:0] rd_base_reg;
    logic [INFO_W-1:0]    rd_info_reg;

    logic                 rd_en;
    logic                 base_we, info_we;
    logic [IDX_W-1:0]     wr_addr;
    logic [ADDR_BITS-1:0] base_wdata;
    logic [INFO_W-1:0]    info_wdata;

    // Datapath helpers
    logic [32:0]          alloc_sum;
    logic [ADDR_BITS-1:0] alloc_top;
    logic [ADDR_BITS-1:0] free_top;
    logic [31:0]          cur_top_ext, alloc_top_ext, free_top_ext;
    logic [31:0]          owner_ext;
    logic [OWNER_BITS-1:0] req_owner;
    logic [15:0]          rd_len;
    logic [OWNER_BITS-1:0] rd_owner;
    logic                 rd_hit;
    logic                 rd_above;

    assign alloc_sum     = 33'(top_reg) + 33'(req_reg.length);
    assign alloc_top     = alloc_sum[ADDR_BITS-1:0];
    assign free_top      = top_reg - ADDR_BITS'(flen_reg);
    assign cur_top_ext   = 32'(top_reg);
    assign alloc_top_ext = 32'(alloc_top);
    assign free_top_ext  = 32'(free_top);
    assign owner_ext     = 32'(req_reg.owner_id);
    assign req_owner     = owner_ext[OWNER_BITS-1:0];
    assign rd_len        = rd_info_reg[INFO_W-1:OWNER_BITS];
    assign rd_owner      = rd_info_reg[OWNER_BITS-1:0];
    assign rd_hit        = valid_reg[rd_idx_reg]
                         && (32'(rd_base_reg) == 32'(req_reg.block_base))
                         && (rd_owner == req_owner);
    assign rd_above      = valid_reg[rd_idx_reg] && (rd_base_reg > fbase_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        valid_next      = valid_reg;
        top_next        = top_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        flen_next       = flen_reg;
        fbase_next      = fbase_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        base_we         = 1'b0;
        info_we         = 1'b0;
        wr_addr         = idx_reg;
        base_wdata      = top_reg;
        info_wdata      = {req_reg.length, req_owner};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next        = s_data;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    state_next      = (s_data.mode == cba_pkg::MODE_FREE) ? S_SEARCH : S_SCAN;
                end
            end

            // Allocate: walk valid bits for the lowest free entry
            S_SCAN: begin
                if (req_reg.length == 16'd0) begin
                    res_next   = '{status: cba_pkg::ST_ZERO, granted_base: 16'd0,
                                   top: cur_top_ext[15:0]};
                    state_next = S_DELIVER;
                end else if (!valid_reg[idx_reg]) begin
                    if (alloc_sum > ADDR_LIMIT) begin
                        res_next = '{status: cba_pkg::ST_SPACE, granted_base: 16'd0,
                                     top: cur_top_ext[15:0]};
                    end else begin
                        base_we             = 1'b1;
                        info_we             = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        top_next            = alloc_top;
                        res_next = '{status: cba_pkg::ST_OK, granted_base: cur_top_ext[15:0],
                                     top: alloc_top_ext[15:0]};
                    end
                    state_next = S_DELIVER;
                end else if (idx_reg == LAST_IDX) begin
                    res_next   = '{status: cba_pkg::ST_FULL, granted_base: 16'd0,
                                   top: cur_top_ext[15:0]};
                    state_next = S_DELIVER;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Free, first pass: find the lowest matching entry
            S_SEARCH: begin
                if (rd_pend_reg && rd_hit) begin
                    valid_next[rd_idx_reg] = 1'b0;
                    flen_next       = rd_len;
                    fbase_next      = rd_base_reg;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    state_next      = S_COMPACT;
                end else begin
                    if (!issue_done_reg) begin
                        rd_en        = 1'b1;
                        rd_pend_next = 1'b1;
                        rd_idx_next  = idx_reg;
                        if (idx_reg == LAST_IDX) begin
                            issue_done_next = 1'b1;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    if (rd_pend_reg && rd_idx_reg == LAST_IDX) begin
                        res_next   = '{status: cba_pkg::ST_MISSING, granted_base: 16'd0,
                                       top: cur_top_ext[15:0]};
                        state_next = S_DELIVER;
                    end
                end
            end

            // Free, second pass: slide blocks above the freed one down
            S_COMPACT: begin
                if (!issue_done_reg) begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = idx_reg;
                    if (idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (rd_pend_reg) begin
                    wr_addr    = rd_idx_reg;
                    base_wdata = rd_base_reg - ADDR_BITS'(flen_reg);
                    base_we    = rd_above;
                    if (rd_idx_reg == LAST_IDX) begin
                        top_next   = free_top;
                        res_next   = '{status: cba_pkg::ST_OK, granted_base: 16'd0,
                                       top: free_top_ext[15:0]};
                        state_next = S_DELIVER;
                    end
                end
            end

            // Hand the result to the output register
            S_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            top_reg        <= ADDR_BITS'(1);
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            top_reg        <= top_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            rd_pend_reg    <= rd_pend_next;
            m_valid_reg    <= m_valid_next;
        end
        req_reg    <= req_next;
        rd_idx_reg <= rd_idx_next;
        flen_reg   <= flen_next;
        fbase_reg  <= fbase_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // Base memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (base_we) begin
            base_mem[wr_addr] <= base_wdata;
        end
        if (rd_en) begin
            rd_base_reg <= base_mem[idx_reg];
        end
    end

    // Length and owner memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (info_we) begin
            info_mem[wr_addr] <= info_wdata;
        end
        if (rd_en) begin
            rd_info_reg <= info_mem[idx_reg];
        end
    end

endmodule

`default_nettype wire
